FILE: src/ipid_pkg.sv
// Shared types and constants of the incremental PID controller.
package ipid_pkg;

  localparam int WIDE_W     = 68;
  localparam int OP_W       = 33;
  localparam int PROD_W     = 2 * OP_W;
  localparam int DIVD_W     = 64;
  localparam int DIVR_W     = 32;
  localparam int DIV_RADIX  = 2;
  localparam int DIV_STEPS  = DIVD_W / DIV_RADIX;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 4;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STICTION_BAND = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_LIMIT  = 4'd7;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_PREP  = 15'h0002,
    S_MP    = 15'h0004,
    S_MI    = 15'h0008,
    S_MT    = 15'h0010,
    S_MT2   = 15'h0020,
    S_MIS   = 15'h0040,
    S_MD    = 15'h0080,
    S_DIV   = 15'h0100,
    S_DSAT  = 15'h0200,
    S_SUM   = 15'h0400,
    S_APPLY = 15'h0800,
    S_CLAMP = 15'h1000,
    S_STIC  = 15'h2000,
    S_EMIT  = 15'h4000
  } state_t;

endpackage

FILE: src/ipid_mul.sv
// Shared signed multiplier with registered product.
module ipid_mul (
  input  logic           clk,
  input  ipid_pkg::op_t   a,
  input  ipid_pkg::op_t   b,
  output ipid_pkg::prod_t p
);
  import ipid_pkg::*;

  always_ff @(posedge clk) begin
    p <= prod_t'(a) * prod_t'(b);
  end

endmodule

FILE: src/ipid_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
module ipid_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       dividend,
  input  logic [31:0]       divisor,
  output logic              done,
  output logic [63:0]       quotient
);
  import ipid_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVR_W-1:0]    rem;
  logic [DIVR_W-1:0]    rem_next;
  logic [DIVD_W-1:0]    quo;
  logic [DIVD_W-1:0]    quo_next;
  logic [DIVR_W-1:0]    dvr;

  always_comb begin
    logic [DIVR_W:0]   t;
    logic [DIVR_W-1:0] r;
    logic [DIVD_W-1:0] q;
    r = rem;
    q = quo;
    for (int i = 0; i < DIV_RADIX; i++) begin
      t = {r, q[DIVD_W-1]};
      q = {q[DIVD_W-2:0], 1'b0};
      if (t >= {1'b0, dvr}) begin
        t = t - {1'b0, dvr};
        q[0] = 1'b1;
      end
      r = t[DIVR_W-1:0];
    end
    rem_next = r;
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvr  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (busy && dvr != '0) |-> rem < dvr)
    else $error("partial remainder not below divisor");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while busy");

endmodule

FILE: src/incremental_pid_controller.sv
// Incremental PID controller top level: sequencer over a shared multiplier and divider.
//
//  channel | signals                                          | direction
//  in      | in_valid in_ready req_type target_value          | into block
//          | measured_value time_stamp                        |
//  out     | out_valid out_ready drive                        | out of block
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data           | into block
//
// A control step runs from one input transfer to the next through the sequencer
// states, with the radix-4 divide by elapsed time in S_DIV between S_MD and S_DSAT.
// First steps go from S_PREP to S_APPLY; zero elapsed time and clears go straight to S_EMIT.
// in_ready is high only while the sequencer is idle; cfg_ready is always high.
// A finished result waits in the output register while the next transfer is
// taken; a step ready to finish stalls until that register frees up.
// Reset is synchronous and restores state, out_valid, the architectural state and the configuration.
module incremental_pid_controller #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               req_type,
  input  logic signed [31:0]                 target_value,
  input  logic signed [31:0]                 measured_value,
  input  logic [31:0]                        time_stamp,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 drive,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);
  import ipid_pkg::*;

  localparam int WB = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam wide_t WMAX = (wide_t'(1) <<< (WB - 1)) - wide_t'(1);
  localparam wide_t WMIN = -WMAX - wide_t'(1);

  typedef logic signed [WB-1:0] word_t;

  function automatic word_t sat(input wide_t v);
    wide_t r;
    if (v > WMAX) r = WMAX;
    else if (v < WMIN) r = WMIN;
    else r = v;
    return r[WB-1:0];
  endfunction

  function automatic wide_t wabs(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // configuration
  logic signed [31:0] prop_gain, integ_gain, deriv_gain, upper_limit, lower_limit;
  logic [30:0]        deadband, stiction_band, windup_limit;

  // architectural state
  word_t       acc, isum, prev_err, prev_tgt;
  logic [31:0] prev_time;

  // step temporaries
  state_t      state;
  word_t       sp, fb, err, d1, diff, p_term, t_term, i_add, d_term, delta, res_val;
  logic [31:0] now_ts, elapsed;
  logic        div_neg;

  word_t kp_s, ki_s, kd_s, up_s, lo_s;
  op_t   mul_a, mul_b;
  prod_t prod, prod_mag, prod_sh;
  logic  div_start, div_done;
  logic [63:0] div_quotient;
  wide_t isum_sum, wu_w, isum_clamped, quo_w;

  assign kp_s = sat(wide_t'(prop_gain));
  assign ki_s = sat(wide_t'(integ_gain));
  assign kd_s = sat(wide_t'(deriv_gain));
  assign up_s = sat(wide_t'(upper_limit));
  assign lo_s = sat(wide_t'(lower_limit));

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MP:  begin mul_a = op_t'(err);    mul_b = op_t'(kp_s); end
      S_MI:  begin mul_a = op_t'(ki_s);   mul_b = op_t'(err); end
      S_MT2: begin mul_a = op_t'(t_term); mul_b = op_t'({1'b0, elapsed}); end
      S_MIS: begin mul_a = op_t'(kd_s);   mul_b = op_t'(diff); end
      default: ;
    endcase
  end

  ipid_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign prod_sh  = prod >>> FRAC_BITS;
  assign prod_mag = prod[PROD_W-1] ? -prod : prod;
  assign div_start = (state == S_MD);

  ipid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_mag[DIVD_W-1:0]),
    .divisor  (elapsed),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign quo_w    = wide_t'(div_quotient);
  assign isum_sum = wide_t'(sat(wide_t'(isum) + wide_t'(i_add)));
  assign wu_w     = wide_t'(windup_limit);

  always_comb begin
    isum_clamped = isum_sum;
    if (wu_w != 0) begin
      if (isum_sum < -wu_w) isum_clamped = -wu_w;
      else if (isum_sum > wu_w) isum_clamped = wu_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      acc           <= '0;
      isum          <= '0;
      prev_err      <= '0;
      prev_tgt      <= '0;
      prev_time     <= '0;
      prop_gain     <= '0;
      integ_gain    <= '0;
      deriv_gain    <= '0;
      deadband      <= '0;
      upper_limit   <= 32'sh7FFF_FFFF;
      lower_limit   <= 32'sh8000_0000;
      stiction_band <= '0;
      windup_limit  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PROP_GAIN:     prop_gain     <= cfg_data;
          REG_INTEG_GAIN:    integ_gain    <= cfg_data;
          REG_DERIV_GAIN:    deriv_gain    <= cfg_data;
          REG_DEADBAND:      deadband      <= cfg_data[30:0];
          REG_UPPER_LIMIT:   upper_limit   <= cfg_data;
          REG_LOWER_LIMIT:   lower_limit   <= cfg_data;
          REG_STICTION_BAND: stiction_band <= cfg_data[30:0];
          REG_WINDUP_LIMIT:  windup_limit  <= cfg_data[30:0];
          default: ;
        endcase
      end

      if (state == S_EMIT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (req_type) begin
              acc       <= '0;
              isum      <= '0;
              prev_err  <= '0;
              prev_tgt  <= '0;
              prev_time <= '0;
              res_val   <= '0;
              state     <= S_EMIT;
            end else begin
              sp     <= sat(wide_t'(target_value));
              fb     <= sat(wide_t'(measured_value));
              now_ts <= time_stamp;
              state  <= S_PREP;
            end
          end
        end
        S_PREP: begin
          err     <= sat(wide_t'(sp) - wide_t'(fb));
          d1      <= sat(wide_t'(sp) - wide_t'(prev_tgt));
          elapsed <= now_ts - prev_time;
          if (prev_time == '0) begin
            prev_time <= now_ts;
            delta     <= '0;
            state     <= S_APPLY;
          end else if (now_ts == prev_time) begin
            res_val <= acc;
            state   <= S_EMIT;
          end else begin
            prev_time <= now_ts;
            state     <= S_MP;
          end
        end
        S_MP: begin
          diff  <= sat(wide_t'(d1) - wide_t'(sat(wide_t'(err) - wide_t'(prev_err))));
          state <= S_MI;
        end
        S_MI: begin
          p_term   <= sat(wide_t'(prod_sh));
          prev_err <= err;
          prev_tgt <= sp;
          state    <= S_MT;
        end
        S_MT: begin
          t_term <= sat(wide_t'(prod_sh));
          state  <= S_MT2;
        end
        S_MT2: state <= S_MIS;
        S_MIS: begin
          i_add <= sat(wide_t'(prod_sh));
          state <= S_MD;
        end
        S_MD: begin
          isum    <= isum_clamped[WB-1:0];
          div_neg <= prod[PROD_W-1];
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state <= S_DSAT;
        end
        S_DSAT: begin
          d_term <= sat(div_neg ? -quo_w : quo_w);
          state  <= S_SUM;
        end
        S_SUM: begin
          delta <= sat(wide_t'(p_term) + wide_t'(isum) + wide_t'(d_term));
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (wabs(wide_t'(delta)) > wide_t'(deadband))
            acc <= sat(wide_t'(acc) + wide_t'(delta));
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (acc > up_s) acc <= up_s;
          else if (acc < lo_s) acc <= lo_s;
          state <= S_STIC;
        end
        S_STIC: begin
          res_val <= (wabs(wide_t'(acc)) < wide_t'(stiction_band)) ? '0 : acc;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            drive <= 32'(res_val);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type) |=> (acc == '0 && isum == '0 && prev_time == '0))
    else $error("clear transfer left state behind");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> elapsed != '0)
    else $error("divide started with zero elapsed time");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("result not loaded into output register");

endmodule
